// ===== rtl/ghf_pkg.sv =====
// ghf_pkg: shared types, codes and helpers of the grid hole filler
// no dependencies
`default_nettype none
package ghf_pkg;

	localparam int VAL_W = 40;
	localparam int LIM_W = 39;
	localparam int SUM_W = 44;   // nine 40-bit samples
	localparam int CNT_W = 4;    // up to nine samples in a window

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_RUN   = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_ROWS  = 2'd0,
		REG_COLS  = 2'd1,
		REG_PASS  = 2'd2,
		REG_LIMIT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]              op;
		logic [5:0]              row_index;
		logic [5:0]              col_index;
		logic signed [VAL_W-1:0] pixel_value;
		logic                    pixel_present;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic                    read_present;
		logic [7:0]              passes_done;
		logic                    grid_was_empty;
	} result_t;

	typedef struct packed {
		logic                    present;
		logic signed [VAL_W-1:0] value;
	} ent_t;

	function automatic logic ent_valid(input ent_t e, input logic [LIM_W-1:0] lim);
		logic [VAL_W-1:0] mag;
		mag = e.value[VAL_W-1] ? VAL_W'(-e.value) : VAL_W'(e.value);
		return e.present && (mag <= {1'b0, lim});
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ghf_ram.sv =====
// ghf_ram: one write port, one registered read port
// uses ghf_pkg for the entry type
`default_nettype none
module ghf_ram #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire ghf_pkg::ent_t   wdata,
	input  wire logic [AW-1:0]   raddr,
	output ghf_pkg::ent_t        rdata
);
	import ghf_pkg::*;

	ent_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/ghf_div.sv =====
// ghf_div: restoring divider, one quotient bit per cycle
// uses ghf_pkg for widths
`default_nettype none
module ghf_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ghf_pkg::SUM_W-1:0] dividend,
	input  wire logic [ghf_pkg::CNT_W-1:0] divisor,
	output logic                           done,
	output logic [ghf_pkg::SUM_W-1:0]      quotient
);
	import ghf_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [SUM_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic [CNT_W:0]    trial;
	logic              take;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign take = trial >= {1'b0, div_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= take ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], take};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/grid_hole_fill_neighbor_mean.sv =====
// grid_hole_fill_neighbor_mean: pixel store with iterative 3x3 mean hole filling
// uses ghf_pkg, ghf_ram, ghf_div
//
//  channel   signals                           direction
//  command   start, busy, cmd                  in (taken when start & !busy)
//  result    done, result                      out (one-cycle strobe)
//  config    psel penable pwrite paddr pwdata  in, prdata/pready out
//
// write and op 3: done in the cycle after the transfer, block stays ready
// read: busy during ST_READ, result after the registered memory read
// run: per-cell time is set by the serial divider, used when a hole has valid
// neighbors, and by the single grid read port; each pass adds a copy-back of the
// region unless the grid had no valid cell. reset clears control only
// the receiver cannot stall; done is high for exactly one cycle per result
`default_nettype none
module grid_hole_fill_neighbor_mean #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire ghf_pkg::cmd_t    cmd,
	output logic                  done,
	output ghf_pkg::result_t      result,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [4:0]       paddr,
	input  wire logic [63:0]      pwdata,
	output logic [63:0]           prdata,
	output logic                  pready
);
	import ghf_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = $clog2(DEPTH);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_READ   = 11'b00000000010,
		ST_WIN    = 11'b00000000100,
		ST_WLAST  = 11'b00000001000,
		ST_DEC    = 11'b00000010000,
		ST_DIV    = 11'b00000100000,
		ST_ENDP   = 11'b00001000000,
		ST_ZERO   = 11'b00010000000,
		ST_COPY   = 11'b00100000000,
		ST_CFLUSH = 11'b01000000000,
		ST_CHK    = 11'b10000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [6:0]       rows_cfg_q, cols_cfg_q;
	logic [7:0]       max_passes_q;
	logic [LIM_W-1:0] limit_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= 7'd64;
			cols_cfg_q <= 7'd64;
			max_passes_q <= '0;
			limit_q <= LIM_W'(64'd65536000000);
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:3]))
				REG_ROWS:  rows_cfg_q <= pwdata[6:0];
				REG_COLS:  cols_cfg_q <= pwdata[6:0];
				REG_PASS:  max_passes_q <= pwdata[7:0];
				REG_LIMIT: limit_q <= pwdata[LIM_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:3]))
			REG_ROWS:  prdata = 64'(rows_cfg_q);
			REG_COLS:  prdata = 64'(cols_cfg_q);
			REG_PASS:  prdata = 64'(max_passes_q);
			REG_LIMIT: prdata = 64'(limit_q);
			default:   prdata = '0;
		endcase
	end

	// region size, saturated to 1..MAX
	logic [RW:0] rows_eff;
	logic [CW:0] cols_eff;
	assign rows_eff = (rows_cfg_q == '0) ? (RW+1)'(1) :
		(32'(rows_cfg_q) > MAX_ROWS) ? (RW+1)'(MAX_ROWS) : (RW+1)'(rows_cfg_q);
	assign cols_eff = (cols_cfg_q == '0) ? (CW+1)'(1) :
		(32'(cols_cfg_q) > MAX_COLS) ? (CW+1)'(MAX_COLS) : (CW+1)'(cols_cfg_q);

	// scan registers
	logic [RW-1:0]    r_q;
	logic [CW-1:0]    c_q;
	logic [1:0]       wr_q, wc_q;
	logic [7:0]       passes_q;
	logic             fvalid_q, finval_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	ent_t             ctr_q;
	logic             neg_q;
	logic             proc_s1, inwin_s1, center_s1;
	logic             cp_s1;
	logic [AW-1:0]    cp_addr_s1;
	logic [7:0]       last_pass_q;
	logic             last_empty_q;
	logic             done_q, rd_inr_q;
	logic signed [VAL_W-1:0] rv_q;
	logic             rp_q;

	// addressing
	logic             in_range;
	logic [AW-1:0]    in_addr, cell_addr, win_addr;
	logic [RW:0]      nr;
	logic [CW:0]      nc;
	logic             nin;
	logic             last_c, last_cell;

	assign in_range = (32'(cmd.row_index) < MAX_ROWS) && (32'(cmd.col_index) < MAX_COLS);
	assign in_addr = AW'(32'(cmd.row_index) * MAX_COLS + 32'(cmd.col_index));
	assign cell_addr = AW'(32'(r_q) * MAX_COLS + 32'(c_q));
	assign nr = {1'b0, r_q} + (RW+1)'(wr_q) - (RW+1)'(1);
	assign nc = {1'b0, c_q} + (CW+1)'(wc_q) - (CW+1)'(1);
	assign nin = (nr < rows_eff) && (nc < cols_eff);
	assign win_addr = AW'(32'(nr[RW-1:0]) * MAX_COLS + 32'(nc[CW-1:0]));
	assign last_c = ({1'b0, c_q} == cols_eff - (CW+1)'(1));
	assign last_cell = last_c && ({1'b0, r_q} == rows_eff - (RW+1)'(1));

	// memories
	logic    g_we, w_we;
	logic [AW-1:0] g_waddr, g_raddr;
	ent_t    g_wdata, g_rdata, w_wdata, w_rdata;

	ghf_ram #(.DEPTH(DEPTH), .AW(AW)) u_grid (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata)
	);

	ghf_ram #(.DEPTH(DEPTH), .AW(AW)) u_work (
		.clk(clk), .we(w_we), .waddr(cell_addr), .wdata(w_wdata),
		.raddr(cell_addr), .rdata(w_rdata)
	);

	// divider
	logic             div_start, div_done;
	logic [SUM_W-1:0] div_q_out, sum_mag;
	logic             ctr_ok;
	ent_t             mean_ent;

	assign ctr_ok = ent_valid(ctr_q, limit_q);
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign div_start = (state_q == ST_DEC) && !ctr_ok && (cnt_q != '0);
	assign mean_ent = {1'b1, (neg_q ? VAL_W'(-div_q_out) : VAL_W'(div_q_out))};

	ghf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sum_mag), .divisor(cnt_q),
		.done(div_done), .quotient(div_q_out)
	);

	always_comb begin
		g_we = 1'b0;
		g_waddr = cell_addr;
		g_wdata = w_rdata;
		g_raddr = (state_q == ST_IDLE) ? in_addr : win_addr;
		if (state_q == ST_IDLE && start && cmd.op == OP_WRITE && in_range) begin
			g_we = 1'b1;
			g_waddr = in_addr;
			g_wdata.present = cmd.pixel_present;
			g_wdata.value = cmd.pixel_value;
		end else if (state_q == ST_ZERO) begin
			g_we = 1'b1;
			g_wdata.present = 1'b1;
			g_wdata.value = '0;
		end else if (cp_s1) begin
			g_we = 1'b1;
			g_waddr = cp_addr_s1;
		end
		w_we = 1'b0;
		w_wdata = ctr_q;
		if (state_q == ST_DEC && (ctr_ok || cnt_q == '0)) begin
			w_we = 1'b1;
		end else if (state_q == ST_DIV && div_done) begin
			w_we = 1'b1;
			w_wdata = mean_ent;
		end
	end

	logic cell_step;
	assign cell_step = w_we || state_q == ST_ZERO || state_q == ST_COPY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			last_pass_q <= '0;
			last_empty_q <= 1'b0;
			proc_s1 <= 1'b0;
			cp_s1 <= 1'b0;
			r_q <= '0;
			c_q <= '0;
			wr_q <= '0;
			wc_q <= '0;
			passes_q <= '0;
			fvalid_q <= 1'b0;
			finval_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			proc_s1 <= (state_q == ST_WIN);
			cp_s1 <= (state_q == ST_COPY);
			if (proc_s1 && inwin_s1 && ent_valid(g_rdata, limit_q)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// walk cells of the region row by row
			if (cell_step) begin
				if (last_cell) begin
					r_q <= '0;
					c_q <= '0;
				end else if (last_c) begin
					c_q <= '0;
					r_q <= r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
			if (w_we) begin
				cnt_q <= '0;
				state_q <= last_cell ? ST_ENDP : ST_WIN;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (cmd.op)
							OP_RUN: begin
								r_q <= '0;
								c_q <= '0;
								wr_q <= '0;
								wc_q <= '0;
								cnt_q <= '0;
								passes_q <= 8'd1;
								fvalid_q <= 1'b0;
								finval_q <= 1'b0;
								last_empty_q <= 1'b0;
								state_q <= ST_WIN;
							end
							OP_READ: state_q <= ST_READ;
							default: done_q <= 1'b1;
						endcase
					end
				end
				ST_READ: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_WIN: begin
					if (wc_q == 2'd2) begin
						wc_q <= '0;
						if (wr_q == 2'd2) begin
							wr_q <= '0;
							state_q <= ST_WLAST;
						end else begin
							wr_q <= wr_q + 1'b1;
						end
					end else begin
						wc_q <= wc_q + 1'b1;
					end
				end
				ST_WLAST: state_q <= ST_DEC;
				ST_DEC: begin
					if (ctr_ok) begin
						fvalid_q <= 1'b1;
					end else begin
						finval_q <= 1'b1;
						if (cnt_q != '0) begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: ;
				ST_ENDP: begin
					if (!fvalid_q) begin
						last_empty_q <= 1'b1;
						state_q <= ST_ZERO;
					end else begin
						state_q <= ST_COPY;
					end
				end
				ST_ZERO: begin
					if (last_cell) begin
						done_q <= 1'b1;
						last_pass_q <= passes_q;
						state_q <= ST_IDLE;
					end
				end
				ST_COPY: begin
					if (last_cell) begin
						state_q <= ST_CFLUSH;
					end
				end
				ST_CFLUSH: state_q <= ST_CHK;
				ST_CHK: begin
					if (!finval_q || (max_passes_q != '0 && passes_q >= max_passes_q) ||
						(32'(passes_q) > 32'(rows_eff) && 32'(passes_q) > 32'(cols_eff))) begin
						done_q <= 1'b1;
						last_pass_q <= passes_q;
						state_q <= ST_IDLE;
					end else begin
						passes_q <= passes_q + 1'b1;
						finval_q <= 1'b0;
						state_q <= ST_WIN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		inwin_s1 <= nin;
		center_s1 <= (wr_q == 2'd1) && (wc_q == 2'd1);
		cp_addr_s1 <= cell_addr;
		if (proc_s1 && inwin_s1 && ent_valid(g_rdata, limit_q)) begin
			sum_q <= sum_q + SUM_W'(g_rdata.value);
		end
		if (proc_s1 && center_s1) begin
			ctr_q <= g_rdata;
		end
		if ((state_q == ST_IDLE && start && cmd.op == OP_RUN) || w_we) begin
			sum_q <= '0;
		end
		if (div_start) begin
			neg_q <= sum_q[SUM_W-1];
		end
		if (state_q == ST_IDLE && start) begin
			rd_inr_q <= in_range;
			rv_q <= '0;
			rp_q <= 1'b0;
		end else if (state_q == ST_READ) begin
			rv_q <= rd_inr_q ? g_rdata.value : '0;
			rp_q <= rd_inr_q && g_rdata.present;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = {rv_q, rp_q, last_pass_q, last_empty_q};

endmodule
`default_nettype wire
